// ----- rtl/ntew_pkg.sv -----
// ntew_pkg: shared constants and word codes for number_to_english_word_tokens
// no dependencies
`default_nettype none

package ntew_pkg;

    localparam int VALUE_W  = 31;              // input integer width
    localparam int DIGITS   = 10;              // decimal digits needed for VALUE_W bits
    localparam int BCD_W    = 4 * DIGITS;
    localparam int GROUPS   = 4;               // units, thousands, millions, billions
    localparam int SLOTS    = 5;               // hundreds digit, hundred, tens, units, scale
    localparam int WORD_W   = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    localparam logic [WORD_W-1:0] CODE_ZERO     = 5'd0;
    localparam logic [WORD_W-1:0] CODE_TEN      = 5'd10;
    localparam logic [WORD_W-1:0] CODE_TENS_OFS = 5'd18;
    localparam logic [WORD_W-1:0] CODE_HUNDRED  = 5'd28;
    localparam logic [WORD_W-1:0] CODE_THOUSAND = 5'd29;
    localparam logic [WORD_W-1:0] CODE_MILLION  = 5'd30;
    localparam logic [WORD_W-1:0] CODE_BILLION  = 5'd31;

    // scale word for a group, counted from the top group (0 = billions)
    function automatic logic [WORD_W-1:0] scale_code(input logic [1:0] top_idx);
        logic [WORD_W-1:0] code;
        unique case (top_idx)
            2'd0:    code = CODE_BILLION;
            2'd1:    code = CODE_MILLION;
            2'd2:    code = CODE_THOUSAND;
            default: code = CODE_ZERO;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/number_to_english_word_tokens.sv -----
// number_to_english_word_tokens: spells a 31-bit integer as a run of english word codes
// depends on ntew_pkg
// sequence: accept, the shift-add-3 conversion loop, then one word slot per cycle while the output is free
// the next item is taken only after the last word is loaded; zero spells as one word; m_tready can stall
// the binary-to-bcd loop reuses one digit-correct/shift datapath, the slot walk steps fixed slots
// s_tready is high only while idle; a finished word waits in the output register
// reset (rst_n, async, active low) clears the sequencer and the output valid
`default_nettype none

module number_to_english_word_tokens
    import ntew_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [30:0] value, [31] zero pad
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [4:0] word_code, [7:5] zero pad
    output logic                        m_tlast    // last_word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    localparam int SLOT_TOTAL = GROUPS * SLOTS;

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;      // binary bits still to shift in
    logic [BCD_W-1:0]   bcd_reg, bcd_next;      // decimal digits being built
    logic [4:0]         cnt_reg, cnt_next;      // conversion steps left after the current one
    logic [1:0]         grp_reg, grp_next;      // group index from the top (0 = billions)
    logic [2:0]         slot_reg, slot_next;    // slot within the group
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_code_reg, out_code_next;
    logic               out_last_reg, out_last_next;

    // digit correct: each digit of 5 or more gets 3 added before the shift
    logic [BCD_W-1:0]   bcd_adj;
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // digits padded to four full groups of three
    logic [4*3*GROUPS-1:0] digits_all;
    assign digits_all = {{(4*3*GROUPS-BCD_W){1'b0}}, bcd_reg};

    // per-slot validity of every word position, top group first
    logic [SLOT_TOTAL-1:0] slot_ok;
    always_comb
    begin
        logic [3:0] h, t, u;
        logic       nz;
        int         g;
        for (int k = 0; k < GROUPS; k++)
        begin
            g  = GROUPS - 1 - k;
            h  = digits_all[12*g + 8 +: 4];
            t  = digits_all[12*g + 4 +: 4];
            u  = digits_all[12*g     +: 4];
            nz = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
            slot_ok[SLOTS*k + 0] = (h != 4'd0);
            slot_ok[SLOTS*k + 1] = (h != 4'd0);
            slot_ok[SLOTS*k + 2] = (t != 4'd0);
            slot_ok[SLOTS*k + 3] = (t != 4'd1) && (u != 4'd0);
            slot_ok[SLOTS*k + 4] = (g != 0) && nz;
        end
    end

    // current slot
    logic [4:0]        idx, idx_p1;
    logic              cur_ok, cur_last, bcd_zero, out_free, out_load;
    logic [3:0]        cur_h, cur_t, cur_u;
    logic [WORD_W-1:0] cur_code;
    logic [SLOT_TOTAL-1:0] later;

    assign idx      = {1'b0, grp_reg, 2'b00} + {3'b000, grp_reg} + {2'b00, slot_reg};
    assign idx_p1   = idx + 5'd1;
    assign cur_ok   = slot_ok[idx];
    assign later    = slot_ok >> idx_p1;
    assign cur_last = (later == '0);
    assign bcd_zero = (bcd_reg == '0);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        logic [1:0] g_lo;
        g_lo  = 2'd3 - grp_reg;
        cur_h = digits_all[{1'b0, g_lo, 3'b000} + {2'b00, g_lo, 2'b00} + 6'd8 +: 4];
        cur_t = digits_all[{1'b0, g_lo, 3'b000} + {2'b00, g_lo, 2'b00} + 6'd4 +: 4];
        cur_u = digits_all[{1'b0, g_lo, 3'b000} + {2'b00, g_lo, 2'b00} +: 4];
    end

    always_comb
    begin
        case (slot_reg)
            3'd0:    cur_code = {1'b0, cur_h};
            3'd1:    cur_code = CODE_HUNDRED;
            3'd2:    cur_code = (cur_t == 4'd1) ? CODE_TEN + {1'b0, cur_u}
                                                : CODE_TENS_OFS + {1'b0, cur_t};
            3'd3:    cur_code = {1'b0, cur_u};
            default: cur_code = scale_code(grp_reg);
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        grp_next       = grp_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;
        out_load       = 1'b0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    bin_next   = s_tdata[VALUE_W-1:0];
                    bcd_next   = '0;
                    cnt_next   = 5'(VALUE_W - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    grp_next   = 2'd0;
                    slot_next  = 3'd0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (bcd_zero)
                begin
                    // zero spells as the single word zero
                    if (out_free)
                    begin
                        out_load       = 1'b1;
                        out_valid_next = 1'b1;
                        out_code_next  = CODE_ZERO;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (!cur_ok || out_free)
                begin
                    if (cur_ok)
                    begin
                        out_load       = 1'b1;
                        out_valid_next = 1'b1;
                        out_code_next  = cur_code;
                        out_last_next  = cur_last;
                    end
                    if (cur_ok && cur_last)
                        state_next = ST_IDLE;
                    else if (slot_reg == 3'(SLOTS - 1))
                    begin
                        slot_next = 3'd0;
                        grp_next  = grp_reg + 2'd1;
                        if (grp_reg == 2'(GROUPS - 1))
                            state_next = ST_IDLE;
                    end
                    else
                        slot_next = slot_reg + 3'd1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            grp_reg       <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            grp_reg       <= grp_next;
            slot_reg      <= slot_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        out_code_reg <= out_code_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-WORD_W){1'b0}}, out_code_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CONV))
        else $error("accepted item did not start conversion");

    a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg == ST_CONV) && (state_reg == ST_EMIT)) |-> ($past(cnt_reg) == 5'd0))
        else $error("conversion ended early");

    a_top_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (bcd_reg[BCD_W-1 -: 4] <= 4'd2))
        else $error("billions digit out of range");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> (state_reg == ST_IDLE))
        else $error("sequencer kept running after last word");
`endif

endmodule

`default_nettype wire
